// ----- design/assert_macros.svh -----
// assertion macros used by the circular queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/cq_pkg.sv -----
// shared types and constants of the circular queue
package cq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        KIND_ENQ   = 2'd0,
        KIND_DEQ   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DATA = 1'b1
    } t_state;

    typedef struct packed {
        logic ok;
        logic is_empty;
        logic is_full;
    } t_step_flags;

endpackage

// ----- design/cq_ram.sv -----
// generic ram: one write port, two registered read ports
module cq_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr_a,
    input  logic [AW-1:0]        i_raddr_b,
    output logic [WIDTH-1:0]     o_rdata_a,
    output logic [WIDTH-1:0]     o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// ----- design/cq_ptr.sv -----
// head, tail, occupancy and capacity registers of the circular queue
module cq_ptr
    import cq_pkg::*;
#(
    parameter  int DEPTH = DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  logic              i_step,
    input  logic [1:0]        i_kind,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [AW-1:0]     o_rd_head,
    output logic [AW-1:0]     o_rd_rear,
    output t_step_flags       o_flags
);
    localparam int OW = $clog2(DEPTH + 1);

    logic [CAP_W-1:0] r_capacity;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [OW-1:0]    r_occ, n_occ;
    logic [OW-1:0]    cap;
    logic             ok;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                              input logic [OW-1:0] c);
        logic [OW-1:0] inc;
        inc = OW'(p) + OW'(1);
        return (inc >= c) ? '0 : AW'(inc);
    endfunction

    // capacity in effect, clamped to 1..DEPTH
    always_comb begin
        if (r_capacity == '0) begin
            cap = OW'(1);
        end else if (32'(r_capacity) > 32'(DEPTH)) begin
            cap = OW'(DEPTH);
        end else begin
            cap = OW'(r_capacity);
        end
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        ok     = 1'b1;
        o_we   = 1'b0;
        case (t_kind'(i_kind))
            KIND_ENQ: begin
                if (r_occ >= cap) begin
                    ok = 1'b0;
                end else begin
                    o_we   = i_step;
                    n_tail = advance(r_tail, cap);
                    n_occ  = r_occ + OW'(1);
                end
            end
            KIND_DEQ: begin
                if (r_occ == '0) begin
                    ok = 1'b0;
                end else begin
                    n_head = advance(r_head, cap);
                    n_occ  = r_occ - OW'(1);
                end
            end
            KIND_QUERY: ok = 1'b1;
            default:    ok = 1'b0;
        endcase
    end

    assign o_waddr          = r_tail;
    assign o_rd_head        = n_head;
    assign o_rd_rear        = (n_tail == '0) ? AW'(cap - OW'(1)) : (n_tail - AW'(1));
    assign o_flags.ok       = ok;
    assign o_flags.is_empty = (n_occ == '0);
    assign o_flags.is_full  = (n_occ == cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_head     <= '0;
            r_tail     <= '0;
            r_occ      <= '0;
        end else if (i_cfg_wr) begin
            r_capacity <= i_cfg_data;
            r_head     <= '0;
            r_tail     <= '0;
            r_occ      <= '0;
        end else if (i_step) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end
endmodule

// ----- design/circular_queue.sv -----
// top level of the circular queue: control, entry store and result register
// Ring-buffer fifo of signed 32-bit words, DEPTH entries built, of which the
// capacity register selects how many are in use (0 acts as 1, values above
// DEPTH act as DEPTH); any capacity write also empties the queue. Each input
// word is an enqueue, a dequeue or a query and gives exactly one result word
// with the success flag, the oldest and newest entries after the step (all
// ones when empty) and the empty and full flags. An item goes as follows: in
// the accept cycle the pointers update, the entry store is written and both
// read ports are addressed at the new head and rear; in the data state, once
// the output register is free, the registered read data of the store moves
// into the output register. The output register parts the two sides, so a
// new word is taken while a result still waits on a stalled output. The
// capacity port is ready whenever no item is in flight.
`include "assert_macros.svh"

module circular_queue
    import cq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // capacity write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CAP_W-1:0]         i_cfg_capacity,
    // input words
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    // result words
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_ok,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_rear_value,
    output logic                     o_is_empty,
    output logic                     o_is_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state           r_state, n_state;
    logic             accept;
    logic             cfg_wr;
    logic             load;

    // pointer unit outputs
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    rd_head;
    logic [AW-1:0]    rd_rear;
    t_step_flags      flags;

    // entry store read data
    logic [DATA_W-1:0] rdata_front;
    logic [DATA_W-1:0] rdata_rear;

    // step context held across the read latency
    t_step_flags       r_flags;
    logic              r_fwd_front;
    logic              r_fwd_rear;
    logic [DATA_W-1:0] r_wdata;

    // output register
    logic              r_out_valid;
    logic              r_ok;
    logic [DATA_W-1:0] r_front;
    logic [DATA_W-1:0] r_rear;
    logic              r_empty;
    logic              r_full;
    logic [DATA_W-1:0] front_sel;
    logic [DATA_W-1:0] rear_sel;

    // a capacity write takes priority over an input word in the same cycle
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != ST_IDLE) || i_cfg_valid;
    assign accept      = i_in_valid && !o_in_stall;

    // result register frees when empty or when its word is taken
    assign load = (r_state == ST_DATA) && (!r_out_valid || !i_out_stall);

    cq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (i_cfg_capacity),
        .i_step     (accept),
        .i_kind     (i_kind),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_rd_head  (rd_head),
        .o_rd_rear  (rd_rear),
        .o_flags    (flags)
    );

    cq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_value),
        .i_re      (accept),
        .i_raddr_a (rd_head),
        .i_raddr_b (rd_rear),
        .o_rdata_a (rdata_front),
        .o_rdata_b (rdata_rear)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_DATA;
            end
            ST_DATA: begin
                if (load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // the read in the write cycle sees old data, so a read of the entry
    // being written takes the incoming word instead
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flags     <= flags;
            r_fwd_front <= we && (waddr == rd_head);
            r_fwd_rear  <= we && (waddr == rd_rear);
            r_wdata     <= i_value;
        end
    end

    // empty queue reports all ones for both ends
    assign front_sel = r_flags.is_empty ? '1 : (r_fwd_front ? r_wdata : rdata_front);
    assign rear_sel  = r_flags.is_empty ? '1 : (r_fwd_rear  ? r_wdata : rdata_rear);

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ok    <= r_flags.ok;
            r_front <= front_sel;
            r_rear  <= rear_sel;
            r_empty <= r_flags.is_empty;
            r_full  <= r_flags.is_full;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_front_value = r_front;
    assign o_rear_value  = r_rear;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;

    // an accepted word always moves on to the read-data cycle
    `CQ_ASSERT(a_accept_to_data, i_clk, i_rst_n, accept |=> (r_state == ST_DATA), "accept did not reach data state")
    // a new result appears only out of the read-data cycle
    `CQ_ASSERT(a_result_source, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == ST_DATA), "result without a step")
    // an empty result carries all ones at both ends
    `CQ_ASSERT(a_empty_ends, i_clk, i_rst_n, (o_out_valid && o_is_empty) |-> ((o_front_value == '1) && (o_rear_value == '1)), "empty result with data")
endmodule

// ----- tb/cq_checker.sv -----
// checker for the circular queue: predicts each result word and compares it
`timescale 1ns / 1ps

module cq_checker
    import cq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CAP_W-1:0]         i_cfg_capacity,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [1:0]               i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic                     i_ok,
    input  logic signed [DATA_W-1:0] i_front_value,
    input  logic signed [DATA_W-1:0] i_rear_value,
    input  logic                     i_is_empty,
    input  logic                     i_is_full,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } t_queue_view;

    // shadow copy of the queue
    logic signed [DATA_W-1:0] ring [DEPTH_DEF];
    logic [3:0]               head_ptr;
    logic [3:0]               tail_ptr;
    logic [4:0]               fill;
    logic [4:0]               live_cap;

    t_queue_view expected_views [$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        $display("[%0t] queue mismatch: %s", $time, msg);
        fail_total++;
    endtask

    // 0 acts as 1, anything above the built depth acts as the depth
    function automatic logic [4:0] clamp_capacity(input logic [CAP_W-1:0] c);
        if (c == '0)
            return 5'd1;
        if (c > DEPTH_DEF)
            return 5'(DEPTH_DEF);
        return c;
    endfunction

    function automatic logic [3:0] next_slot(input logic [3:0] p);
        return ({1'b0, p} + 5'd1 >= live_cap) ? 4'd0 : p + 4'd1;
    endfunction

    function automatic t_queue_view predict_step(input t_kind kind,
                                                 input logic signed [DATA_W-1:0] value);
        t_queue_view view;
        logic [3:0]  rear_idx;
        view.ok = 1'b1;
        case (kind)
            KIND_ENQ: begin
                if (fill >= live_cap) begin
                    view.ok = 1'b0;
                end else begin
                    ring[tail_ptr] = value;
                    tail_ptr       = next_slot(tail_ptr);
                    fill           = fill + 5'd1;
                end
            end
            KIND_DEQ: begin
                if (fill == '0) begin
                    view.ok = 1'b0;
                end else begin
                    head_ptr = next_slot(head_ptr);
                    fill     = fill - 5'd1;
                end
            end
            KIND_BAD: begin
                view.ok = 1'b0;
            end
            default: begin
            end
        endcase
        view.front_value = '1;
        view.rear_value  = '1;
        if (fill != '0) begin
            rear_idx         = (tail_ptr == '0) ? 4'(live_cap - 5'd1) : tail_ptr - 4'd1;
            view.front_value = ring[head_ptr];
            view.rear_value  = ring[rear_idx];
        end
        view.is_empty = (fill == '0);
        view.is_full  = (fill == live_cap);
        return view;
    endfunction

    always @(posedge i_clk) begin
        t_queue_view want;
        if (!i_rst_n) begin
            head_ptr = '0;
            tail_ptr = '0;
            fill     = '0;
            live_cap = clamp_capacity(CAP_RESET);
            expected_views.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_views.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected, front %h",
                                              i_front_value));
                end else begin
                    want = expected_views.pop_front();
                    if (i_ok !== want.ok)
                        report_mismatch($sformatf("ok got %b want %b", i_ok, want.ok));
                    if (i_front_value !== want.front_value)
                        report_mismatch($sformatf("front_value got %h want %h",
                                                  i_front_value, want.front_value));
                    if (i_rear_value !== want.rear_value)
                        report_mismatch($sformatf("rear_value got %h want %h",
                                                  i_rear_value, want.rear_value));
                    if (i_is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty got %b want %b",
                                                  i_is_empty, want.is_empty));
                    if (i_is_full !== want.is_full)
                        report_mismatch($sformatf("is_full got %b want %b",
                                                  i_is_full, want.is_full));
                end
            end
            // a capacity write also empties the queue
            if (i_cfg_valid && i_cfg_ready) begin
                live_cap = clamp_capacity(i_cfg_capacity);
                head_ptr = '0;
                tail_ptr = '0;
                fill     = '0;
            end
            if (i_in_valid && !i_in_stall)
                expected_views.push_back(predict_step(t_kind'(i_kind), i_value));
        end
        o_pending <= expected_views.size();
    end

endmodule

// ----- tb/testbench.sv -----
// top of the circular queue testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import cq_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 240;

    // clock and reset, held low from time zero
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // every block input starts at a known value
    logic                     cfg_valid    = 1'b0;
    logic [CAP_W-1:0]         cfg_capacity = '0;
    logic                     in_valid     = 1'b0;
    logic [1:0]               in_kind      = KIND_QUERY;
    logic signed [DATA_W-1:0] in_value     = '0;
    logic                     out_stall    = 1'b0;

    logic                     cfg_ready;
    logic                     in_stall;
    logic                     out_valid;
    logic                     res_ok;
    logic signed [DATA_W-1:0] res_front;
    logic signed [DATA_W-1:0] res_rear;
    logic                     res_empty;
    logic                     res_full;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // sender burst bookkeeping
    int burst_left = 0;

    // receiver stall pattern state
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    circular_queue dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_capacity (cfg_capacity),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (in_kind),
        .i_value        (in_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_ok           (res_ok),
        .o_front_value  (res_front),
        .o_rear_value   (res_rear),
        .o_is_empty     (res_empty),
        .o_is_full      (res_full)
    );

    cq_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_capacity (cfg_capacity),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_kind         (in_kind),
        .i_value        (in_value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_ok           (res_ok),
        .i_front_value  (res_front),
        .i_rear_value   (res_rear),
        .i_is_empty     (res_empty),
        .i_is_full      (res_full),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // receiver: switches between stall patterns, each held for a random stretch
    // 0 never stalls, 1 coin flip, 2 mostly stalled, 3 regular on-off from the tick counter
    always @(posedge clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_tick[2];
        endcase
    end

    // offers one word, opening a new burst after a random gap when the
    // current one is used up; valid stays high across back-to-back words
    task automatic send_item(input t_kind kind, input logic signed [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_value <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // stop sending and wait until every result word has come back; the
    // pending count is registered and is checked only once the loop has waited on the clock
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // capacity is only written with the queue idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        repeat (2) @(posedge clk);
        cfg_valid    <= 1'b1;
        cfg_capacity <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // run time limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("circular_queue test failed");
        $finish;
    end

    initial begin
        logic [CAP_W-1:0]         cap;
        logic signed [DATA_W-1:0] v;
        t_kind                    kind;
        int                       enq_pct;
        int                       roll;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset capacity of 16, empty queue first
        send_item(KIND_QUERY, 32'sd0);
        send_item(KIND_DEQ, 32'sd0);          // dequeue on empty fails
        send_item(KIND_BAD, 32'sd0);          // unknown kind reports ok low
        send_item(KIND_ENQ, 32'sh8000_0000);  // most negative word
        send_item(KIND_ENQ, 32'sh7FFF_FFFF);  // most positive word
        send_item(KIND_ENQ, -32'sd1);         // all ones, same as empty marker
        send_item(KIND_ENQ, 32'sd0);
        send_item(KIND_QUERY, 32'sh1234_5678);
        send_item(KIND_BAD, 32'sh5555_AAAA);
        send_item(KIND_DEQ, 32'sd0);
        send_item(KIND_DEQ, 32'sd0);

        // smallest capacity: one word fills it
        write_capacity(5'd1);
        send_item(KIND_ENQ, 32'sh0BAD_F00D);
        send_item(KIND_ENQ, 32'sh0000_0001);  // full, refused
        send_item(KIND_QUERY, 32'sd0);

        // write while holding a word: queue comes back empty
        write_capacity(5'd0);
        send_item(KIND_QUERY, 32'sd0);
        send_item(KIND_ENQ, 32'shCAFE_0000);
        send_item(KIND_ENQ, 32'sh0000_CAFE);  // capacity 0 acts as 1
        send_item(KIND_DEQ, 32'sd0);
        send_item(KIND_DEQ, 32'sd0);

        // above the built depth: acts as the full depth
        write_capacity(5'd31);
        send_item(KIND_ENQ, 32'sh0F0F_0F0F);
        send_item(KIND_QUERY, 32'sd0);

        // random phases, each with its own capacity; the last two random
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       cap = 5'd16;
                1:       cap = 5'd2;
                2:       cap = 5'd17;
                3:       cap = 5'd5;
                4:       cap = 5'd1;
                5:       cap = 5'd0;
                default: cap = CAP_W'($urandom_range(0, 31));
            endcase
            write_capacity(cap);
            enq_pct = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // swing between filling and draining so full and empty both hit
                if (n % 30 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       enq_pct = 25;
                        1:       enq_pct = 50;
                        default: enq_pct = 80;
                    endcase
                end
                // one full drain mid-phase with the sender held off
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    kind = KIND_BAD;
                else if (roll < 10)
                    kind = KIND_QUERY;
                else if (roll < 10 + (90 * enq_pct) / 100)
                    kind = KIND_ENQ;
                else
                    kind = KIND_DEQ;
                case ($urandom_range(0, 15))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = -32'sd1;
                    3:       v = 32'sd0;
                    default: v = $urandom;
                endcase
                send_item(kind, v);
            end
        end

        drain_results();
        repeat (4) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("circular_queue test passed");
        end else begin
            $display("circular_queue test failed");
        end
        $finish;
    end

endmodule
